[src/cad_pkg.sv]
// Shared constants, types and angle table for the CORDIC atan2 pipeline.
package cad_pkg;

   // number of vectoring cells in the chain (1 to 8)
   localparam int ITERATIONS      = 7;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int INPUT_WIDTH     = 16;
   localparam int OUT_WIDTH       = 25;

   // x/y datapath: magnitude plus CORDIC growth plus sign, with headroom
   localparam int XY_WIDTH  = INPUT_WIDTH + 4;
   // angle accumulator width
   localparam int SUM_WIDTH = OUT_WIDTH;
   // shift amount / table index width
   localparam int IDX_WIDTH = 3;

   // 180 degrees in the angle format
   localparam logic signed [SUM_WIDTH-1:0] HALF_TURN =
      SUM_WIDTH'(180 * (64'd1 << ANGLE_FRAC_BITS));

   // atan(2^-i) in degrees: milli-degrees times 2^ANGLE_FRAC_BITS / 1000, rounded to nearest
   // (45, 26.565, 14.036, 7.125, 3.576, 1.790, 0.895, 0.448)
   localparam logic signed [SUM_WIDTH-1:0] ATAN_TABLE [8] = '{
      SUM_WIDTH'(((64'd45000 << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd26565 << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd14036 << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd7125  << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd3576  << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd1790  << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd895   << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000),
      SUM_WIDTH'(((64'd448   << ANGLE_FRAC_BITS) + 64'd500) / 64'd1000)
   };

   // payload carried from cell to cell
   typedef struct packed {
      logic                        y_neg;
      logic                        x_neg;
      logic signed [XY_WIDTH-1:0]  x;
      logic signed [XY_WIDTH-1:0]  y;
      logic signed [SUM_WIDTH-1:0] sum;
   } stage_type;

endpackage

[src/cad_cell.sv]
// One vectoring CORDIC rotation cell of the pipeline chain.
module cad_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [cad_pkg::IDX_WIDTH-1:0]        shift,
   input  logic                                 in_valid,
   input  cad_pkg::stage_type                   in_stage,
   output logic                                 out_valid,
   output cad_pkg::stage_type                   out_stage
);

   logic               valid_ff;
   cad_pkg::stage_type stage_ff;
   cad_pkg::stage_type stage_in;
   logic signed [cad_pkg::XY_WIDTH-1:0]  x_sh;
   logic signed [cad_pkg::XY_WIDTH-1:0]  y_sh;
   logic signed [cad_pkg::SUM_WIDTH-1:0] angle;

   // rotate toward the x axis; y at zero means done, pass through
   always_comb begin
      x_sh     = in_stage.x >>> shift;
      y_sh     = in_stage.y >>> shift;
      angle    = cad_pkg::ATAN_TABLE[shift];
      stage_in = in_stage;
      if (in_stage.y != '0) begin
         if (!in_stage.y[cad_pkg::XY_WIDTH-1]) begin
            stage_in.x   = in_stage.x + y_sh;
            stage_in.y   = in_stage.y - x_sh;
            stage_in.sum = in_stage.sum + angle;
         end else begin
            stage_in.x   = in_stage.x - y_sh;
            stage_in.y   = in_stage.y + x_sh;
            stage_in.sum = in_stage.sum - angle;
         end
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[src/cad_quad.sv]
// Quadrant correction and output register of the atan2 pipeline.
module cad_quad (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  cad_pkg::stage_type                   in_stage,
   output logic                                 rsp_valid,
   output logic signed [cad_pkg::OUT_WIDTH-1:0] rsp_angle_deg
);

   logic                                  valid_ff;
   logic signed [cad_pkg::OUT_WIDTH-1:0]  angle_ff;
   logic signed [cad_pkg::OUT_WIDTH-1:0]  angle_in;

   // map first-quadrant angle onto the full circle
   always_comb begin
      case ({in_stage.x_neg, in_stage.y_neg})
         2'b00:   angle_in = in_stage.sum;
         2'b01:   angle_in = -in_stage.sum;
         2'b10:   angle_in = cad_pkg::HALF_TURN - in_stage.sum;
         default: angle_in = in_stage.sum - cad_pkg::HALF_TURN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_angle_deg = angle_ff;

endmodule

[src/cordic_atan2_degrees_top.sv]
// rsp_valid rises once a request has passed the front, rotation and quadrant registers.
// Throughput: one request per cycle; busy is always low, each cell is one pipeline stage.
// The chain is one magnitude stage, one cell per rotation, then the quadrant stage.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Results appear for one cycle on rsp_valid and the receiver cannot stall.
module cordic_atan2_degrees_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [cad_pkg::INPUT_WIDTH-1:0] req_y_in,
   input  logic signed [cad_pkg::INPUT_WIDTH-1:0] req_x_in,
   output logic                                   rsp_valid,
   output logic signed [cad_pkg::OUT_WIDTH-1:0]   rsp_angle_deg
);

   logic                                 front_valid_ff;
   cad_pkg::stage_type                   front_ff;
   cad_pkg::stage_type                   front_in;
   logic signed [cad_pkg::XY_WIDTH-1:0]  y_ext;
   logic signed [cad_pkg::XY_WIDTH-1:0]  x_ext;

   logic               chain_valid [cad_pkg::ITERATIONS+1];
   cad_pkg::stage_type chain_stage [cad_pkg::ITERATIONS+1];

   // pipeline never stalls
   assign busy = 1'b0;

   // front stage: signs and magnitudes
   always_comb begin
      y_ext          = cad_pkg::XY_WIDTH'(req_y_in);
      x_ext          = cad_pkg::XY_WIDTH'(req_x_in);
      front_in.y_neg = req_y_in[cad_pkg::INPUT_WIDTH-1];
      front_in.x_neg = req_x_in[cad_pkg::INPUT_WIDTH-1];
      front_in.y     = front_in.y_neg ? -y_ext : y_ext;
      front_in.x     = front_in.x_neg ? -x_ext : x_ext;
      front_in.sum   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

   assign chain_valid[0] = front_valid_ff;
   assign chain_stage[0] = front_ff;

   // rotation cells
   for (genvar i = 0; i < cad_pkg::ITERATIONS; i++) begin : g_cell
      cad_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (cad_pkg::IDX_WIDTH'(i)),
         .in_valid  (chain_valid[i]),
         .in_stage  (chain_stage[i]),
         .out_valid (chain_valid[i+1]),
         .out_stage (chain_stage[i+1])
      );
   end

   // quadrant correction and output
   cad_quad u_quad (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[cad_pkg::ITERATIONS]),
      .in_stage      (chain_stage[cad_pkg::ITERATIONS]),
      .rsp_valid     (rsp_valid),
      .rsp_angle_deg (rsp_angle_deg)
   );

endmodule
